/* rtl/core/tli_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the tape interpreter.
package tli_pkg;

   localparam int PROG_DEPTH = 1024;
   localparam int DATA_DEPTH = 256;

   localparam int PA_W       = $clog2(PROG_DEPTH);
   localparam int DA_W       = $clog2(DATA_DEPTH);
   localparam int PC_W       = PA_W + 1;
   localparam int CMD_W      = 3;
   localparam int ADDR_W     = 10;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 11;
   localparam int SIZE_W     = 9;
   localparam int SH_W       = SIZE_W + 1;
   localparam int IO_W       = 2;
   localparam int ERR_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int WIDE_W     = 18;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SIZE      = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_PROG = 3'd0,
      CMD_LOAD_DATA = 3'd1,
      CMD_STEP      = 3'd2,
      CMD_CHECK     = 3'd3,
      CMD_REWIND    = 3'd4
   } tli_cmd_type;

   localparam logic [IO_W-1:0] IO_PASS     = 2'd0;
   localparam logic [IO_W-1:0] IO_WAIT_IN  = 2'd1;
   localparam logic [IO_W-1:0] IO_WAIT_OUT = 2'd2;

   localparam logic [ERR_W-1:0] ERR_PASS       = 3'd0;
   localparam logic [ERR_W-1:0] ERR_ZERO_SIZE  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd2;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_UNBALANCED = 3'd4;

   localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;

   typedef struct packed {
      logic accept;
      logic prog_wr;
      logic data_wr;
      logic rewind;
      logic err_size;
      logic chk_start;
      logic fetch;
      logic exec;
      logic scan_rd;
      logic scan_ev;
      logic chk_ev;
      logic cell_rd;
      logic rsp_load;
   } tli_ctl_type;

   typedef struct packed {
      tli_cmd_type cmd;
      logic        at_end;
      logic        size_zero;
      logic        scan_begin;
      logic        scan_done;
      logic        chk_done;
   } tli_sts_type;

endpackage

/* rtl/core/tli_req_if.sv */
// Request and response channel interfaces of the tape interpreter.
interface tli_req_if;
   import tli_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   address;
   logic [BYTE_W-1:0]   value;

   modport source (output valid, output command, output address, output value, input ready);
   modport sink   (input valid, input command, input address, input value, output ready);
endinterface

interface tli_rsp_if;
   import tli_pkg::*;

   logic                valid;
   logic                ready;
   logic [IO_W-1:0]     io_status;
   logic [ERR_W-1:0]    error_code;
   logic [BYTE_W-1:0]   cell_value;
   logic [DA_W-1:0]     data_index;
   logic [PC_W-1:0]     program_index;
   logic                at_end;

   modport source (output valid, output io_status, output error_code, output cell_value,
                   output data_index, output program_index, output at_end, input ready);
   modport sink   (input valid, input io_status, input error_code, input cell_value,
                   input data_index, input program_index, input at_end, output ready);
endinterface

/* rtl/core/tli_datapath.sv */
// Datapath: program and data stores, pointers, scan and check counters, response register.
module tli_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tli_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tli_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [tli_pkg::CMD_W-1:0]      req_command,
   input  logic [tli_pkg::ADDR_W-1:0]     req_address,
   input  logic [tli_pkg::BYTE_W-1:0]     req_value,
   input  tli_pkg::tli_ctl_type           ctl,
   output tli_pkg::tli_sts_type           sts,
   output logic [tli_pkg::IO_W-1:0]       rsp_io_status,
   output logic [tli_pkg::ERR_W-1:0]      rsp_error_code,
   output logic [tli_pkg::BYTE_W-1:0]     rsp_cell_value,
   output logic [tli_pkg::DA_W-1:0]       rsp_data_index,
   output logic [tli_pkg::PC_W-1:0]       rsp_program_index,
   output logic                           rsp_at_end
);
   import tli_pkg::*;

   logic [LEN_W-1:0]  len_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [PC_W-1:0]   eff_len;

   logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
   logic [BYTE_W-1:0] prog_rd_ff;
   logic              prog_re;
   logic [PA_W-1:0]   prog_raddr;
   logic [WIDE_W-1:0] addr_ext;
   logic              prog_addr_ok;
   logic              data_addr_ok;

   logic [BYTE_W-1:0]     data_mem [DATA_DEPTH];
   logic [DATA_DEPTH-1:0] data_vld_ff;
   logic [BYTE_W-1:0]     data_rd_ff;
   logic                  data_rd_vld_ff;
   logic                  data_re;
   logic                  dw_en;
   logic [DA_W-1:0]       dw_addr;
   logic [BYTE_W-1:0]     dw_data;
   logic [BYTE_W-1:0]     cur_cell;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [DA_W-1:0]  dp_ff, dp_in;
   logic [PC_W-1:0]  idx_ff, idx_in;
   logic [PC_W-1:0]  depth_ff, depth_in;
   logic [SH_W-1:0]  shift_ff, shift_in;
   logic             fwd_ff, fwd_in;
   logic [IO_W-1:0]  io_ff, io_in;
   logic [ERR_W-1:0] err_ff, err_in;

   logic [BYTE_W-1:0] op;
   logic [PC_W-1:0]   pc_inc;
   logic [PC_W-1:0]   pc_dec;
   logic [PC_W-1:0]   idx_inc;
   logic [PC_W-1:0]   scan_depth_nx;
   logic              scan_match;
   logic              scan_last;
   logic              chk_fail;
   logic [ERR_W-1:0]  chk_code;
   logic [SH_W-1:0]   chk_shift_nx;
   logic [PC_W-1:0]   chk_depth_nx;
   logic              chk_last;
   logic              at_end_now;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         size_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROGRAM_LENGTH: len_ff  <= LEN_W'(csr_wdata);
            CSR_DATA_SIZE:      size_ff <= SIZE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign eff_len = (WIDE_W'(len_ff) > WIDE_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH)
                                                           : PC_W'(len_ff);

   assign addr_ext     = WIDE_W'(req_address);
   assign prog_addr_ok = addr_ext < WIDE_W'(PROG_DEPTH);
   assign data_addr_ok = addr_ext < WIDE_W'(DATA_DEPTH);

   // program store: one write port and one registered read port
   assign prog_re    = ctl.fetch | ctl.scan_rd;
   assign prog_raddr = ctl.fetch ? pc_ff[PA_W-1:0] : idx_ff[PA_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.prog_wr && prog_addr_ok) begin
         prog_mem[addr_ext[PA_W-1:0]] <= req_value;
      end
      if (prog_re) begin
         prog_rd_ff <= prog_mem[prog_raddr];
      end
   end

   assign op = prog_rd_ff;

   // data store: cells never written read as zero through the valid bits
   assign data_re  = ctl.fetch | ctl.cell_rd;
   assign cur_cell = data_rd_vld_ff ? data_rd_ff : '0;

   always_comb begin
      dw_en   = (ctl.data_wr && data_addr_ok) ||
                (ctl.exec && (op == OP_INC || op == OP_DEC));
      dw_addr = ctl.data_wr ? addr_ext[DA_W-1:0] : dp_ff;
      if (ctl.data_wr) begin
         dw_data = req_value;
      end else if (op == OP_INC) begin
         dw_data = cur_cell + BYTE_W'(1);
      end else begin
         dw_data = cur_cell - BYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (dw_en) begin
         data_mem[dw_addr] <= dw_data;
      end
      if (data_re) begin
         data_rd_ff     <= data_mem[dp_ff];
         data_rd_vld_ff <= data_vld_ff[dp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_vld_ff <= '0;
      end else if (dw_en) begin
         data_vld_ff[dw_addr] <= 1'b1;
      end
   end

   // step, scan and check arithmetic
   assign pc_inc  = pc_ff + PC_W'(1);
   assign pc_dec  = pc_ff - PC_W'(1);
   assign idx_inc = idx_ff + PC_W'(1);

   always_comb begin
      scan_depth_nx = depth_ff;
      if (op == OP_OPEN) begin
         scan_depth_nx = fwd_ff ? depth_ff + PC_W'(1) : depth_ff - PC_W'(1);
      end else if (op == OP_CLOSE) begin
         scan_depth_nx = fwd_ff ? depth_ff - PC_W'(1) : depth_ff + PC_W'(1);
      end
   end

   assign scan_match = (scan_depth_nx == '0);
   assign scan_last  = fwd_ff ? (idx_inc >= eff_len) : (idx_ff == '0);

   always_comb begin
      chk_fail     = 1'b0;
      chk_code     = ERR_PASS;
      chk_shift_nx = shift_ff;
      chk_depth_nx = depth_ff;
      case (op)
         OP_RIGHT: begin
            chk_shift_nx = shift_ff + SH_W'(1);
            if (WIDE_W'(chk_shift_nx) > WIDE_W'(size_ff)) begin
               chk_fail = 1'b1;
               chk_code = ERR_OVERFLOW;
            end
         end
         OP_LEFT: begin
            if (shift_ff == '0) begin
               chk_fail = 1'b1;
               chk_code = ERR_UNDERFLOW;
            end else begin
               chk_shift_nx = shift_ff - SH_W'(1);
            end
         end
         OP_OPEN: chk_depth_nx = depth_ff + PC_W'(1);
         OP_CLOSE: begin
            if (depth_ff == '0) begin
               chk_fail = 1'b1;
               chk_code = ERR_UNBALANCED;
            end else begin
               chk_depth_nx = depth_ff - PC_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign chk_last   = idx_inc >= eff_len;
   assign at_end_now = pc_ff >= eff_len;

   assign sts.cmd        = tli_cmd_type'(req_command);
   assign sts.at_end     = at_end_now;
   assign sts.size_zero  = (size_ff == '0) || (eff_len == '0);
   assign sts.scan_begin = (op == OP_OPEN && cur_cell == '0 && pc_inc < eff_len) ||
                           (op == OP_CLOSE && cur_cell != '0 && pc_ff != '0);
   assign sts.scan_done  = scan_match || scan_last;
   assign sts.chk_done   = chk_fail || chk_last;

   always_comb begin
      pc_in    = pc_ff;
      dp_in    = dp_ff;
      idx_in   = idx_ff;
      depth_in = depth_ff;
      shift_in = shift_ff;
      fwd_in   = fwd_ff;
      io_in    = io_ff;
      err_in   = err_ff;
      if (ctl.accept) begin
         io_in  = IO_PASS;
         err_in = ERR_PASS;
      end
      if (ctl.rewind) begin
         pc_in = '0;
         dp_in = '0;
      end
      if (ctl.err_size) begin
         err_in = ERR_ZERO_SIZE;
      end
      if (ctl.chk_start) begin
         idx_in   = '0;
         shift_in = '0;
         depth_in = '0;
      end
      if (ctl.exec) begin
         if (sts.scan_begin) begin
            // hold the counter; the scan decides where it lands
            idx_in   = (op == OP_OPEN) ? pc_inc : pc_dec;
            depth_in = PC_W'(1);
            fwd_in   = (op == OP_OPEN);
         end else begin
            pc_in = pc_inc;
            case (op)
               OP_RIGHT: dp_in = dp_ff + DA_W'(1);
               OP_LEFT:  dp_in = dp_ff - DA_W'(1);
               OP_IN:    io_in = IO_WAIT_IN;
               OP_OUT:   io_in = IO_WAIT_OUT;
               default: ;
            endcase
         end
      end
      if (ctl.scan_ev) begin
         if (scan_match) begin
            pc_in = idx_inc;
         end else if (scan_last) begin
            pc_in = pc_inc;
         end else begin
            idx_in   = fwd_ff ? idx_inc : idx_ff - PC_W'(1);
            depth_in = scan_depth_nx;
         end
      end
      if (ctl.chk_ev) begin
         shift_in = chk_shift_nx;
         depth_in = chk_depth_nx;
         idx_in   = idx_inc;
         if (chk_fail) begin
            err_in = chk_code;
         end else if (chk_last) begin
            err_in = (chk_depth_nx != '0) ? ERR_UNBALANCED : ERR_PASS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         dp_ff    <= '0;
         idx_ff   <= '0;
         depth_ff <= '0;
         shift_ff <= '0;
         fwd_ff   <= 1'b0;
         io_ff    <= IO_PASS;
         err_ff   <= ERR_PASS;
      end else begin
         pc_ff    <= pc_in;
         dp_ff    <= dp_in;
         idx_ff   <= idx_in;
         depth_ff <= depth_in;
         shift_ff <= shift_in;
         fwd_ff   <= fwd_in;
         io_ff    <= io_in;
         err_ff   <= err_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_io_status     <= io_ff;
         rsp_error_code    <= err_ff;
         rsp_cell_value    <= cur_cell;
         rsp_data_index    <= dp_ff;
         rsp_program_index <= pc_ff;
         rsp_at_end        <= at_end_now;
      end
   end

endmodule

/* rtl/core/tli_controller.sv */
// Controller: sequences each request through fetch, execute, scan, check and response.
module tli_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tli_pkg::tli_sts_type sts,
   output tli_pkg::tli_ctl_type ctl
);
   import tli_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_FETCH   = 9'b000000010,
      S_EXEC    = 9'b000000100,
      S_SCAN_RD = 9'b000001000,
      S_SCAN_EV = 9'b000010000,
      S_CHK_RD  = 9'b000100000,
      S_CHK_EV  = 9'b001000000,
      S_CELL_RD = 9'b010000000,
      S_RESP    = 9'b100000000
   } tli_state_type;

   tli_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctl.accept = 1'b1;
               state_in   = S_CELL_RD;
               unique case (sts.cmd)
                  CMD_LOAD_PROG: ctl.prog_wr = 1'b1;
                  CMD_LOAD_DATA: ctl.data_wr = 1'b1;
                  CMD_REWIND:    ctl.rewind  = 1'b1;
                  CMD_STEP: begin
                     if (!sts.at_end) begin
                        state_in = S_FETCH;
                     end
                  end
                  CMD_CHECK: begin
                     if (sts.size_zero) begin
                        ctl.err_size = 1'b1;
                     end else begin
                        ctl.chk_start = 1'b1;
                        state_in      = S_CHK_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            ctl.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.scan_begin ? S_SCAN_RD : S_CELL_RD;
         end
         S_SCAN_RD: begin
            ctl.scan_rd = 1'b1;
            state_in    = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            ctl.scan_ev = 1'b1;
            state_in    = sts.scan_done ? S_CELL_RD : S_SCAN_RD;
         end
         S_CHK_RD: begin
            ctl.scan_rd = 1'b1;
            state_in    = S_CHK_EV;
         end
         S_CHK_EV: begin
            ctl.chk_ev = 1'b1;
            state_in   = sts.chk_done ? S_CELL_RD : S_CHK_RD;
         end
         S_CELL_RD: begin
            ctl.cell_rd = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/tape_language_interpreter_core.sv */
// Top level of the tape interpreter: controller, datapath and channel hookup.
//
//  port      dir   handshake          carries
//  req_bus   in    valid/ready        command, address, value
//  rsp_bus   out   valid/ready        io_status, error_code, cell_value, data_index,
//                                     program_index, at_end
//  csr_*     in    csr_we, no stall   program_length (index 0), data_size (index 1)
//
// Loads, rewind, unused commands and a step at program end go via the cell read to
// the result; a plain step adds fetch and execute. A bracket scan or a check adds
// a read and an evaluate state per program byte, all set by the single registered
// read port of the program store. Reset is synchronous and needs no clearing pass:
// data cells carry valid bits. A stalled result sits in the output register while
// the next request is accepted; a second result waits behind it.
module tape_language_interpreter_core (
   input  logic                           clock,
   input  logic                           reset,
   tli_req_if.sink                        req_bus,
   tli_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [tli_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tli_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tli_pkg::*;

   tli_ctl_type ctl;
   tli_sts_type sts;
   logic        req_ready;
   logic        rsp_valid;

   tli_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tli_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_bus.command),
      .req_address       (req_bus.address),
      .req_value         (req_bus.value),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_io_status     (rsp_bus.io_status),
      .rsp_error_code    (rsp_bus.error_code),
      .rsp_cell_value    (rsp_bus.cell_value),
      .rsp_data_index    (rsp_bus.data_index),
      .rsp_program_index (rsp_bus.program_index),
      .rsp_at_end        (rsp_bus.at_end)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule
